FILE: src/dcsv_pkg.sv
// Types and constants of the dual-channel safety voter.
// Standalone package, used by src/dual_channel_safety_voter.sv.
`default_nettype none

package dcsv_pkg;

  localparam int unsigned TsW  = 63;
  localparam int unsigned CntW = 32;
  localparam int unsigned TolW = 32;

  localparam logic [TolW-1:0] TOL_RESET = 32'd100000000;
  localparam logic [CntW-1:0] CNT_MAX   = '1;

  // Channel flag bit positions
  localparam int unsigned FLAG_TORQUE = 0;
  localparam int unsigned FLAG_MOTION = 1;
  localparam int unsigned FLAG_BRAKE  = 2;
  localparam int unsigned FLAG_FAULT  = 3;

  localparam logic [3:0] FAULT_DISCREPANCY = 4'd1;
  localparam logic [2:0] STATE_STO         = 3'd0;

  typedef struct packed {
    logic [3:0]     chan_a_flags;
    logic [15:0]    chan_a_speed_limit;
    logic [2:0]     chan_a_state;
    logic [3:0]     chan_a_fault;
    logic [3:0]     chan_b_flags;
    logic [15:0]    chan_b_speed_limit;
    logic [2:0]     chan_b_state;
    logic [3:0]     chan_b_fault;
    logic [TsW-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic            torque_ok;
    logic            motion_ok;
    logic            brake_on;
    logic            fault_held;
    logic [15:0]     speed_cap;
    logic [2:0]      safety_state;
    logic [3:0]      fault_code;
    logic            force_fault;
    logic [CntW-1:0] disagree_count;
    logic [TsW-1:0]  longest_disagree;
    logic [CntW-1:0] discrepancy_count;
  } out_item_t;

endpackage

`default_nettype wire

FILE: src/dual_channel_safety_voter.sv
// One-out-of-two safety voter with discrepancy timer and latch.
// Depends on src/dcsv_pkg.sv for payload types and constants.
//
//   port group    | dir | handshake                | beat
//   in_*          | in  | in_valid_i / in_stall_o  | dcsv_pkg::in_item_t
//   out_*         | out | out_valid_o / out_stall_i| dcsv_pkg::out_item_t
//   cfg_*         | in  | cfg_valid_i / cfg_ready_o| 32-bit discrepancy tolerance
//
// One beat per cycle sustained while the output is not stalled.
// The vote, the 63-bit span subtract and the tolerance/longest compares sit between
// the input register and the result register.
// Reset clears the latch, span timer and counters; tolerance resets to 100000000 ns.
// A stalled output holds the result register and then the input register back.
`default_nettype none

module dual_channel_safety_voter (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dcsv_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dcsv_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [31:0]         cfg_data_i
);

  localparam int unsigned TsW  = dcsv_pkg::TsW;
  localparam int unsigned CntW = dcsv_pkg::CntW;
  localparam int unsigned TolW = dcsv_pkg::TolW;

  logic                 in_vld_q;
  dcsv_pkg::in_item_t   in_q;
  logic                 out_vld_q;
  dcsv_pkg::out_item_t  out_q, out_d;

  logic [TolW-1:0] tol_q;
  logic            active_q, active_d;
  logic [TsW-1:0]  start_q, start_d;
  logic            latch_q, latch_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic [TsW-1:0]  longest_q, longest_d;
  logic [CntW-1:0] trips_q, trips_d;

  logic out_adv, in_adv, in_take;

  // Result register advances when empty or drained; input register follows.
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign in_adv     = in_vld_q && out_adv;
  assign in_stall_o = in_vld_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= dcsv_pkg::TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Vote logic
  logic           differ, trip, safe, latch_now;
  logic [TsW:0]   diff;
  logic [TsW-1:0] dur;
  logic [3:0]     fa, fb;

  always_comb begin
    fa     = in_q.chan_a_flags;
    fb     = in_q.chan_b_flags;
    differ = in_q.chan_a_state != in_q.chan_b_state;

    start_d  = active_q ? start_q : in_q.timestamp;
    active_d = differ;
    if (!differ) begin
      start_d = start_q;
    end

    // Borrow out means time ran backward: clamp the span to zero.
    diff = {1'b0, in_q.timestamp} - {1'b0, start_d};
    dur  = diff[TsW] ? '0 : diff[TsW-1:0];

    steps_d   = steps_q;
    longest_d = longest_q;
    trip      = 1'b0;
    if (differ) begin
      if (steps_q != dcsv_pkg::CNT_MAX) begin
        steps_d = steps_q + 1'b1;
      end
      if (dur > longest_q) begin
        longest_d = dur;
      end
      trip = (dur > {{(TsW-TolW){1'b0}}, tol_q}) && !latch_q;
    end

    trips_d = trips_q;
    if (trip && trips_q != dcsv_pkg::CNT_MAX) begin
      trips_d = trips_q + 1'b1;
    end

    // Release only when neither channel still reports a latched fault.
    latch_now = latch_q || trip;
    safe      = latch_now && (trip || fa[dcsv_pkg::FLAG_FAULT] || fb[dcsv_pkg::FLAG_FAULT]);
    latch_d   = safe;

    if (safe) begin
      out_d.torque_ok    = 1'b0;
      out_d.motion_ok    = 1'b0;
      out_d.brake_on     = 1'b1;
      out_d.fault_held   = 1'b1;
      out_d.speed_cap    = '0;
      out_d.safety_state = dcsv_pkg::STATE_STO;
      out_d.fault_code   = dcsv_pkg::FAULT_DISCREPANCY;
    end else begin
      out_d.torque_ok    = fa[dcsv_pkg::FLAG_TORQUE] & fb[dcsv_pkg::FLAG_TORQUE];
      out_d.motion_ok    = fa[dcsv_pkg::FLAG_MOTION] & fb[dcsv_pkg::FLAG_MOTION];
      out_d.brake_on     = fa[dcsv_pkg::FLAG_BRAKE] | fb[dcsv_pkg::FLAG_BRAKE];
      out_d.fault_held   = fa[dcsv_pkg::FLAG_FAULT] | fb[dcsv_pkg::FLAG_FAULT];
      out_d.speed_cap    = (in_q.chan_a_speed_limit < in_q.chan_b_speed_limit) ?
                           in_q.chan_a_speed_limit : in_q.chan_b_speed_limit;
      out_d.safety_state = (in_q.chan_a_state < in_q.chan_b_state) ?
                           in_q.chan_a_state : in_q.chan_b_state;
      out_d.fault_code   = (in_q.chan_a_fault != '0) ? in_q.chan_a_fault : in_q.chan_b_fault;
    end
    out_d.force_fault       = trip;
    out_d.disagree_count    = steps_d;
    out_d.longest_disagree  = longest_d;
    out_d.discrepancy_count = trips_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      start_q   <= '0;
      latch_q   <= 1'b0;
      steps_q   <= '0;
      longest_q <= '0;
      trips_q   <= '0;
    end else if (in_adv) begin
      active_q  <= active_d;
      start_q   <= start_d;
      latch_q   <= latch_d;
      steps_q   <= steps_d;
      longest_q <= longest_d;
      trips_q   <= trips_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Latch can only be set by a trip beat, which lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(latch_q) |-> (out_vld_q && out_q.force_fault))
    else $error("discrepancy latch set without a force_fault beat");

  // A trip beat always carries the safe result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.force_fault) |->
      (!out_q.torque_ok && !out_q.motion_ok && out_q.brake_on && out_q.fault_held &&
       out_q.fault_code == dcsv_pkg::FAULT_DISCREPANCY && out_q.discrepancy_count != '0))
    else $error("trip beat without safe result");

  // Longest span never shrinks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (longest_q >= $past(longest_q)))
    else $error("longest disagreement decreased");

  // Span timer only runs while a disagreement is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && !active_d) |=> !active_q)
    else $error("span timer active after agreement");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for dual_channel_safety_voter.
// Needs src/dcsv_pkg.sv and src/dual_channel_safety_voter.sv. A clocked driver and
// monitor run against a built-in vote predictor, with random gaps on both sides.
`timescale 1ns / 100ps

module tb;
  import dcsv_pkg::*;

  localparam logic [TsW-1:0] TS_MAX = '1;

  typedef enum logic [1:0] {EP_AGREE, EP_SPLIT, EP_HOLD, EP_NOISE} episode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  dual_channel_safety_voter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Voter state as predicted
  logic [TolW-1:0] tol_ns          = TOL_RESET;
  logic            span_open       = 1'b0;
  logic [TsW-1:0]  span_begin      = '0;
  logic            latched         = 1'b0;
  logic [CntW-1:0] split_steps     = '0;
  logic [TsW-1:0]  longest_span_ns = '0;
  logic [CntW-1:0] trip_total      = '0;

  in_item_t    sample_q[$];
  out_item_t   vote_q[$];
  int unsigned n_loaded  = 0;
  int unsigned n_checked = 0;
  int unsigned errors    = 0;
  int unsigned in_gap    = 0;
  int unsigned out_gap   = 0;
  bit          calm_in   = 1'b0;
  bit          calm_out  = 1'b0;

  logic [TsW-1:0] t_now   = '0;
  episode_e       ep      = EP_AGREE;
  int unsigned    ep_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout: results stopped arriving");
    $display("Mismatches found");
    $finish;
  end

  function automatic out_item_t vote_result(in_item_t it);
    out_item_t      r;
    logic [TsW-1:0] span;
    logic           tripped;
    logic           safe;
    r       = '0;
    span    = '0;
    tripped = 1'b0;
    safe    = 1'b0;
    if (it.chan_a_state != it.chan_b_state) begin
      if (split_steps != CNT_MAX) split_steps++;
      if (!span_open) begin
        span_open  = 1'b1;
        span_begin = it.timestamp;
      end
      // clamp a backward timestamp to a zero span
      span = (it.timestamp >= span_begin) ? it.timestamp - span_begin : '0;
      if (span > longest_span_ns) longest_span_ns = span;
      if (span > TsW'(tol_ns) && !latched) begin
        latched = 1'b1;
        if (trip_total != CNT_MAX) trip_total++;
        tripped = 1'b1;
      end
    end else begin
      span_open = 1'b0;
    end
    if (latched) begin
      if (!tripped && !it.chan_a_flags[FLAG_FAULT] && !it.chan_b_flags[FLAG_FAULT]) begin
        latched = 1'b0;
      end else begin
        safe = 1'b1;
      end
    end
    if (safe) begin
      r.brake_on     = 1'b1;
      r.fault_held   = 1'b1;
      r.safety_state = STATE_STO;
      r.fault_code   = FAULT_DISCREPANCY;
    end else begin
      r.torque_ok    = it.chan_a_flags[FLAG_TORQUE] & it.chan_b_flags[FLAG_TORQUE];
      r.motion_ok    = it.chan_a_flags[FLAG_MOTION] & it.chan_b_flags[FLAG_MOTION];
      r.brake_on     = it.chan_a_flags[FLAG_BRAKE] | it.chan_b_flags[FLAG_BRAKE];
      r.fault_held   = it.chan_a_flags[FLAG_FAULT] | it.chan_b_flags[FLAG_FAULT];
      r.speed_cap    = (it.chan_a_speed_limit < it.chan_b_speed_limit) ?
                       it.chan_a_speed_limit : it.chan_b_speed_limit;
      r.safety_state = (it.chan_a_state < it.chan_b_state) ?
                       it.chan_a_state : it.chan_b_state;
      r.fault_code   = (it.chan_a_fault != 4'd0) ? it.chan_a_fault : it.chan_b_fault;
    end
    r.force_fault       = tripped;
    r.disagree_count    = split_steps;
    r.longest_disagree  = longest_span_ns;
    r.discrepancy_count = trip_total;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic in_item_t pair(logic [3:0] fa, logic [15:0] sla, logic [2:0] sta,
                                    logic [3:0] fca, logic [3:0] fb, logic [15:0] slb,
                                    logic [2:0] stb, logic [3:0] fcb, logic [TsW-1:0] ts);
    return {fa, sla, sta, fca, fb, slb, stb, fcb, ts};
  endfunction

  // Time advance scaled to the tolerance so spans land on both sides of it
  function automatic logic [TsW-1:0] time_step();
    logic [TsW-1:0] unit;
    unit = TsW'(tol_ns) / 3 + 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TsW'(1);
      2, 3, 4: return TsW'($urandom) % unit;
      5, 6:    return unit + TsW'($urandom) % unit;
      7:       return TsW'(tol_ns);
      8:       return TsW'(tol_ns) + 1;
      default: return TsW'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t    it;
    int unsigned r;
    if (ep_left == 0) begin
      r       = $urandom_range(0, 9);
      ep      = (r < 3) ? EP_AGREE : (r < 7) ? EP_SPLIT : (r < 9) ? EP_HOLD : EP_NOISE;
      ep_left = $urandom_range(1, 8);
    end
    ep_left--;
    it.chan_a_flags       = 4'($urandom);
    it.chan_b_flags       = 4'($urandom);
    it.chan_a_speed_limit = 16'($urandom);
    it.chan_b_speed_limit = 16'($urandom);
    it.chan_a_fault       = 4'($urandom);
    it.chan_b_fault       = 4'($urandom);
    it.chan_a_state       = 3'($urandom);
    it.chan_b_state       = it.chan_a_state;
    case (ep)
      EP_SPLIT: begin
        it.chan_b_state = it.chan_a_state + 3'($urandom_range(1, 7));
      end
      EP_HOLD: begin
        // keep the latch held most of the time
        if ($urandom_range(0, 3) != 0) it.chan_a_flags[FLAG_FAULT] = 1'b1;
      end
      EP_AGREE: begin
        if ($urandom_range(0, 1) != 0) begin
          it.chan_a_flags[FLAG_FAULT] = 1'b0;
          it.chan_b_flags[FLAG_FAULT] = 1'b0;
        end
      end
      default: begin
        it.chan_b_state = 3'($urandom);
      end
    endcase
    if (ep == EP_NOISE) begin
      t_now = {31'($urandom), 32'($urandom)};
    end else if ($urandom_range(0, 29) == 0) begin
      t_now = (t_now > 1000) ? t_now - TsW'($urandom_range(1, 1000)) : '0;
    end else begin
      t_now = t_now + time_step();
    end
    it.timestamp = t_now;
    return it;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (sample_q.size() != 0 || n_loaded != n_checked);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tol_ns = value;
  endtask

  // Driver: predict each accepted beat, hold the payload while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) vote_q.push_back(vote_result(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data_i  <= sample_q.pop_front();
          in_valid_i <= 1'b1;
          n_loaded++;
          in_gap = calm_in ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest predicted vote
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (vote_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with no vote pending, actual %0h", $time, out_data_o);
        end else begin
          want = vote_q.pop_front();
          check_field("torque_ok", 64'(want.torque_ok), 64'(out_data_o.torque_ok));
          check_field("motion_ok", 64'(want.motion_ok), 64'(out_data_o.motion_ok));
          check_field("brake_on", 64'(want.brake_on), 64'(out_data_o.brake_on));
          check_field("fault_held", 64'(want.fault_held), 64'(out_data_o.fault_held));
          check_field("speed_cap", 64'(want.speed_cap), 64'(out_data_o.speed_cap));
          check_field("safety_state", 64'(want.safety_state),
                      64'(out_data_o.safety_state));
          check_field("fault_code", 64'(want.fault_code), 64'(out_data_o.fault_code));
          check_field("force_fault", 64'(want.force_fault), 64'(out_data_o.force_fault));
          check_field("disagree_count", 64'(want.disagree_count),
                      64'(out_data_o.disagree_count));
          check_field("longest_disagree", 64'(want.longest_disagree),
                      64'(out_data_o.longest_disagree));
          check_field("discrepancy_count", 64'(want.discrepancy_count),
                      64'(out_data_o.discrepancy_count));
          n_checked++;
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap = calm_out ? 0 : pick_gap();
      end
    end
  end

  initial begin
    logic [31:0]    tol_plan [6];
    logic [TsW-1:0] t0;
    int unsigned    n_directed;
    t0          = TsW'(1000);
    tol_plan[0] = TOL_RESET;
    tol_plan[1] = 32'd0;
    tol_plan[2] = 32'hFFFF_FFFF;
    tol_plan[3] = 32'd25;
    tol_plan[4] = $urandom;
    tol_plan[5] = TOL_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes and the plain combine
    sample_q.push_back(pair(4'h0, 16'h0000, 3'd0, 4'h0, 4'h0, 16'h0000, 3'd0, 4'h0, '0));
    sample_q.push_back(pair(4'hF, 16'hFFFF, 3'd7, 4'hF, 4'hF, 16'hFFFF, 3'd7, 4'hF,
                            TsW'(10)));
    sample_q.push_back(pair(4'h5, 16'h1234, 3'd2, 4'h0, 4'hA, 16'hFFFF, 3'd2, 4'h5,
                            TsW'(20)));
    sample_q.push_back(pair(4'h3, 16'hFFFF, 3'd4, 4'h9, 4'h3, 16'h0001, 3'd4, 4'h2,
                            TsW'(30)));
    // span reaches the tolerance exactly, then one past it trips
    sample_q.push_back(pair(4'h3, 16'h0100, 3'd3, 4'h0, 4'h3, 16'h0200, 3'd5, 4'h0, t0));
    sample_q.push_back(pair(4'h3, 16'h0100, 3'd3, 4'h0, 4'h3, 16'h0200, 3'd5, 4'h0,
                            t0 + TsW'(TOL_RESET)));
    sample_q.push_back(pair(4'h3, 16'h0100, 3'd3, 4'h0, 4'h3, 16'h0200, 3'd5, 4'h0,
                            t0 + TsW'(TOL_RESET) + 1));
    // latch held by either fault bit, then released with both clear
    sample_q.push_back(pair(4'hB, 16'h0100, 3'd3, 4'h0, 4'h3, 16'h0200, 3'd3, 4'h0,
                            t0 + TsW'(TOL_RESET) + 2));
    sample_q.push_back(pair(4'h3, 16'h0100, 3'd3, 4'h0, 4'hB, 16'h0200, 3'd3, 4'h0,
                            t0 + TsW'(TOL_RESET) + 3));
    sample_q.push_back(pair(4'h3, 16'h0100, 3'd3, 4'h6, 4'h3, 16'h0200, 3'd3, 4'h0,
                            t0 + TsW'(TOL_RESET) + 4));
    // longest possible span, backward time, release while still split
    sample_q.push_back(pair(4'h7, 16'h8000, 3'd6, 4'h0, 4'h7, 16'h7FFF, 3'd1, 4'h3, '0));
    sample_q.push_back(pair(4'h7, 16'h8000, 3'd6, 4'h0, 4'h7, 16'h7FFF, 3'd1, 4'h3, TS_MAX));
    sample_q.push_back(pair(4'h7, 16'h8000, 3'd6, 4'h0, 4'h7, 16'h7FFF, 3'd1, 4'h3,
                            TsW'(5)));
    sample_q.push_back(pair(4'h7, 16'h8000, 3'd6, 4'h0, 4'h7, 16'h7FFF, 3'd1, 4'h3, TS_MAX));
    sample_q.push_back(pair(4'hF, 16'h8000, 3'd2, 4'h0, 4'hF, 16'h7FFF, 3'd2, 4'h3, TS_MAX));
    sample_q.push_back(pair(4'h7, 16'h8000, 3'd2, 4'h0, 4'h7, 16'h7FFF, 3'd2, 4'h3, TS_MAX));
    sample_q.push_back(pair(4'h1, 16'h0000, 3'd7, 4'h1, 4'h2, 16'hFFFF, 3'd0, 4'h0, TS_MAX));
    sample_q.push_back(pair(4'h1, 16'h0000, 3'd7, 4'h1, 4'h2, 16'hFFFF, 3'd7, 4'h0, TS_MAX));
    n_directed = sample_q.size();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        wait_idle();
        set_tolerance(tol_plan[ph]);
      end
      calm_in  = (ph % 3 == 1);
      calm_out = (ph % 3 == 2);
      repeat (108) sample_q.push_back(random_sample());
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d votes (%0d directed) across 6 tolerance settings.",
             n_checked, n_directed);
    $display("Predicted %0d discrepancy trips and %0d split-state steps.",
             trip_total, split_steps);
    if (errors == 0 && vote_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
